FILE: src/rgb_to_hsv_pixel_top_macros.svh
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_top_macros.svh : assertion macros for the HSV pipeline
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_TOP_MACROS_SVH
`define RGB_TO_HSV_PIXEL_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define HSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("HSV pipeline check failed");

// Next-cycle implication, disabled in reset
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("HSV pipeline check failed");

`endif

FILE: src/hsv_pkg.sv
// ---------------------------------------------------------------------------
// hsv_pkg : shared types and constants for the RGB to HSV pipeline
// Holds the divider stage payload and the scale factors.
// ---------------------------------------------------------------------------
package hsv_pkg;

   localparam int unsigned COMP_W    = 8;
   localparam int unsigned QUOT_W    = 8;
   localparam int unsigned HUE_NUM_W = 17;  // n * 85, n < 1530
   localparam int unsigned HUE_DEN_W = 9;   // 2 * C
   localparam int unsigned SAT_NUM_W = 16;  // 255 * C
   localparam int unsigned SAT_DEN_W = 8;   // max
   localparam int unsigned SECT_W    = 11;  // n = sector base * C + diff

   // 255 / 360 reduced: hue = n * 85 / (2 * C)
   localparam logic [HUE_NUM_W-1:0] HUE_SCALE = HUE_NUM_W'(85);
   localparam logic [SAT_NUM_W-1:0] SAT_SCALE = SAT_NUM_W'(255);

   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // Payload carried through the divider steps
   typedef struct packed {
      logic [HUE_NUM_W-1:0] hue_rem;
      logic [HUE_DEN_W-1:0] hue_den;
      logic [QUOT_W-1:0]    hue_q;
      logic [SAT_NUM_W-1:0] sat_rem;
      logic [SAT_DEN_W-1:0] sat_den;
      logic [QUOT_W-1:0]    sat_q;
      logic [COMP_W-1:0]    val;
      logic                 gray;
   } div_type;

endpackage

FILE: src/rgb_to_hsv_pixel_top.sv
// Pipeline: 2 set-up stages, 8 divide stages and 1 output register from request accept to rsp_valid.
// Throughput: one request per cycle while the output is not stalled; each divider bit is its own pipeline stage.
// Stalls back-pressure stage by stage; empty stages fill up while the output waits.
// Reset (synchronous, active high) clears all stage valid bits; no data is cleared.
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_top : 8-bit RGB to HSV pixel pipeline
// Front end, eight restoring-division steps and an output register.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_top_macros.svh"

module rgb_to_hsv_pixel_top
   import hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [COMP_W-1:0] req_red,
   input  logic [COMP_W-1:0] req_green,
   input  logic [COMP_W-1:0] req_blue,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [QUOT_W-1:0] rsp_hue_out,
   output logic [QUOT_W-1:0] rsp_sat_out,
   output logic [COMP_W-1:0] rsp_val_out
);

   localparam int unsigned NUM_STEPS = QUOT_W;

   logic [NUM_STEPS:0] stg_valid;
   logic [NUM_STEPS:0] stg_ready;
   div_type            stg_data [NUM_STEPS+1];

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_ready;
   logic [QUOT_W-1:0]  rsp_hue_ff, rsp_hue_in;
   logic [QUOT_W-1:0]  rsp_sat_ff, rsp_sat_in;
   logic [COMP_W-1:0]  rsp_val_ff, rsp_val_in;
   div_type            last;

   // Front end: extrema, sector and dividends
   hsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   // Divider steps, most significant quotient bit first
   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
      hsv_div_step #(
         .BIT_POS (NUM_STEPS - 1 - i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   // Output register: force gray pixels to zero hue and saturation
   assign last                 = stg_data[NUM_STEPS];
   assign out_ready            = !rsp_valid_ff || rsp_ready;
   assign stg_ready[NUM_STEPS] = out_ready;

   always_comb begin
      rsp_hue_in   = last.gray ? '0 : last.hue_q;
      rsp_sat_in   = last.gray ? '0 : last.sat_q;
      rsp_val_in   = last.val;
      rsp_valid_in = out_ready ? stg_valid[NUM_STEPS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[NUM_STEPS]) begin
         rsp_hue_ff <= rsp_hue_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_val_ff <= rsp_val_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hue_out = rsp_hue_ff;
   assign rsp_sat_out = rsp_sat_ff;
   assign rsp_val_out = rsp_val_ff;

   // Zero saturation only for gray pixels, which carry zero hue
   `HSV_ASSERT_NOW(a_gray_hue, clock, reset,
      rsp_valid_ff && (rsp_sat_ff == '0), rsp_hue_ff == '0)

   // Finished divisions leave remainders below their divisors
   `HSV_ASSERT_NOW(a_rem_bound, clock, reset,
      stg_valid[NUM_STEPS] && !last.gray,
      (last.hue_rem < HUE_NUM_W'(last.hue_den)) && (last.sat_rem < SAT_NUM_W'(last.sat_den)))

   // A stalled last divider step keeps its request
   `HSV_ASSERT_NEXT(a_step_hold, clock, reset,
      stg_valid[NUM_STEPS] && !out_ready, stg_valid[NUM_STEPS] && $stable(last))

endmodule

FILE: src/hsv_front.sv
// ---------------------------------------------------------------------------
// hsv_front : extrema, sector and dividend set-up
// Two register stages: max/min/chroma, then hue and saturation dividends.
// ---------------------------------------------------------------------------
module hsv_front
   import hsv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COMP_W-1:0]     in_red,
   input  logic [COMP_W-1:0]     in_green,
   input  logic [COMP_W-1:0]     in_blue,
   output logic                  out_valid,
   input  logic                  out_ready,
   output div_type               out_data
);

   logic                a_valid_ff, a_valid_in;
   logic                a_ready;
   logic [COMP_W-1:0]   a_max_ff, a_max_in;
   logic [COMP_W-1:0]   a_chroma_ff, a_chroma_in;
   sector_type          a_sect_ff, a_sect_in;
   logic signed [COMP_W:0] a_diff_ff, a_diff_in;

   logic                b_valid_ff, b_valid_in;
   logic                b_ready;
   div_type             b_data_ff, b_data_in;

   logic [COMP_W-1:0]   mx_rg, mn_rg, mx, mn;
   logic [SECT_W-1:0]   base;
   logic [SECT_W-1:0]   n;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // Stage A: extrema, chroma and sector, blue over green over red
   always_comb begin
      mx_rg       = (in_red > in_green) ? in_red : in_green;
      mx          = (mx_rg > in_blue) ? mx_rg : in_blue;
      mn_rg       = (in_red < in_green) ? in_red : in_green;
      mn          = (mn_rg < in_blue) ? mn_rg : in_blue;
      a_max_in    = mx;
      a_chroma_in = mx - mn;
      if (mx == in_blue) begin
         a_sect_in = SECT_BLUE;
         a_diff_in = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
      end else if (mx == in_green) begin
         a_sect_in = SECT_GREEN;
         a_diff_in = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
      end else begin
         a_sect_in = SECT_RED;
         a_diff_in = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
      end
      a_valid_in = a_ready ? in_valid : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_max_ff    <= a_max_in;
         a_chroma_ff <= a_chroma_in;
         a_sect_ff   <= a_sect_in;
         a_diff_ff   <= a_diff_in;
      end
   end

   // Stage B: sector angle in units of 60 degrees times C, then dividends
   always_comb begin
      case (a_sect_ff)
         SECT_BLUE:  base = SECT_W'(a_chroma_ff) << 2;
         SECT_GREEN: base = SECT_W'(a_chroma_ff) << 1;
         default: begin
            // wrap a negative red angle by a full turn
            if (a_diff_ff < 0) begin
               base = (SECT_W'(a_chroma_ff) << 2) + (SECT_W'(a_chroma_ff) << 1);
            end else begin
               base = '0;
            end
         end
      endcase
      n = base + {{(SECT_W-COMP_W-1){a_diff_ff[COMP_W]}}, a_diff_ff};

      b_data_in.hue_rem = HUE_NUM_W'(n) * HUE_SCALE;
      b_data_in.hue_den = {a_chroma_ff, 1'b0};
      b_data_in.hue_q   = '0;
      b_data_in.sat_rem = SAT_NUM_W'(a_chroma_ff) * SAT_SCALE;
      b_data_in.sat_den = a_max_ff;
      b_data_in.sat_q   = '0;
      b_data_in.val     = a_max_ff;
      b_data_in.gray    = (a_chroma_ff == '0);
      b_valid_in        = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

FILE: src/hsv_div_step.sv
// ---------------------------------------------------------------------------
// hsv_div_step : one restoring-division step for hue and saturation
// Tries the divisor shifted by BIT_POS and shifts one quotient bit in.
// ---------------------------------------------------------------------------
module hsv_div_step
   import hsv_pkg::*;
#(
   parameter int unsigned BIT_POS = 7
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic                 valid_ff, valid_in;
   div_type              data_ff, data_in;
   logic [HUE_NUM_W-1:0] hue_trial;
   logic [SAT_NUM_W-1:0] sat_trial;
   logic                 hue_fit, sat_fit;

   assign in_ready = !valid_ff || out_ready;

   // Compare and subtract for both quotients
   always_comb begin
      hue_trial = HUE_NUM_W'(in_data.hue_den) << BIT_POS;
      sat_trial = SAT_NUM_W'(in_data.sat_den) << BIT_POS;
      hue_fit   = (in_data.hue_rem >= hue_trial);
      sat_fit   = (in_data.sat_rem >= sat_trial);

      data_in         = in_data;
      data_in.hue_rem = hue_fit ? (in_data.hue_rem - hue_trial) : in_data.hue_rem;
      data_in.sat_rem = sat_fit ? (in_data.sat_rem - sat_trial) : in_data.sat_rem;
      data_in.hue_q   = {in_data.hue_q[QUOT_W-2:0], hue_fit};
      data_in.sat_q   = {in_data.sat_q[QUOT_W-2:0], sat_fit};
      valid_in        = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
